// File: rtl/core/mpmac_pkg.sv
// Package for the median/average battery classifier.
// Holds sizes, register indexes, state codes and shared types. No dependencies.
package mpmac_pkg;
  localparam int PORTS   = 8;
  localparam int SAMPLES = 32;
  localparam int WINDOW  = 12;
  localparam int PW = 3;               // port field width
  localparam int CW = $clog2(SAMPLES + 1);
  localparam int WPW = $clog2(WINDOW + 1);
  localparam int WIW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WAW = $clog2(PORTS * WINDOW);   // window store address
  localparam int SUMW = 18 + WPW;

  typedef enum logic [2:0] {
    REG_CAL   = 3'd0,
    REG_ABS   = 3'd1,
    REG_FULL  = 3'd2,
    REG_FLOAT = 3'd3,
    REG_FAULT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0, ST_CHARGING = 2'd1, ST_FULL = 2'd2, ST_FAULT = 2'd3
  } pstate_t;

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_SUM, S_DIV, S_OUT
  } fsm_t;

  // control from sequencer to cell row
  typedef struct packed {
    logic        ins;     // insert key this cycle
    logic [11:0] key;
  } cell_ctl_t;
endpackage

// File: rtl/core/mpmac_cell.sv
// One sorting cell of the insertion row.
// Depends on mpmac_pkg.
module mpmac_cell (
  input  logic                 clk,
  input  mpmac_pkg::cell_ctl_t ctl,
  input  logic                 idx_ok,   // this cell holds a live entry
  input  logic                 prv_gt,   // left neighbor > key
  input  logic [11:0]          prv_val,
  output logic                 gt,       // this cell > key
  output logic [11:0]          val
);
  import mpmac_pkg::*;
  assign gt = idx_ok && (val > ctl.key);
  // shift right when left neighbor is larger; place key at the boundary
  always_ff @(posedge clk) begin
    if (ctl.ins && !gt) begin
      if (prv_gt) val <= prv_val;
      else if (!idx_ok) val <= ctl.key;
    end else if (ctl.ins && gt) begin
      val <= prv_gt ? prv_val : ctl.key;
    end
  end
endmodule

// File: rtl/core/mpmac_row.sv
// Row of SAMPLES insertion cells keeping a burst in sorted order.
// Depends on mpmac_pkg, mpmac_cell.
module mpmac_row (
  input  logic                 clk,
  input  mpmac_pkg::cell_ctl_t ctl,
  input  logic [mpmac_pkg::CW-1:0] count,
  output logic [11:0]          median
);
  import mpmac_pkg::*;
  logic [11:0] v [SAMPLES];
  logic        g [SAMPLES];
  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    logic ok;
    assign ok = (CW'(i) < count);
    if (i == 0) begin : g_first
      mpmac_cell u_c (.clk, .ctl, .idx_ok(ok), .prv_gt(1'b0), .prv_val(ctl.key),
                      .gt(g[i]), .val(v[i]));
    end else begin : g_rest
      mpmac_cell u_c (.clk, .ctl, .idx_ok(ok), .prv_gt(g[i-1]), .prv_val(v[i-1]),
                      .gt(g[i]), .val(v[i]));
    end
  end
  assign median = v[SAMPLES/2];
endmodule

// File: rtl/core/multi_port_median_average_classifier.sv
// Top level of the median/average battery classifier.
// Depends on mpmac_pkg, mpmac_row.
//
// Usage: samples come in on the s_axis channel, tdata = {pin_mv, port}, tuser = op.
// op 0 inserts one sample into the sorting cell row; every SAMPLES-th
// sample closes the burst: the upper median is scaled by 2*calibration, written
// to the port's window, the window is summed one entry a cycle, divided by 16n
// with a restoring divider (one quotient bit a cycle), classified and handed
// to the m_axis output register.
// The input takes no new sample until the previous one is done, including a
// burst close with its window sum walk and serial divide.
// op 1 clears every full latch and gives no result.
// m_axis tdata = {state_changed, port_state, battery_mv, port_out}.
// When the receiver stalls the result waits in the output register and the
// input side takes no new request until it is taken.
// Reset (rst, synchronous) restores register defaults, empties the windows,
// latches, previous states and burst count. The window store is 96 entries
// with one valid bit per port through the fill pointer; no clearing pass.
// Config: cfg_we/cfg_addr/cfg_wdata; an out-of-band calibration write is ignored.
module multi_port_median_average_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] port, [14:3] pin_mv, zero pad
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] port_out, [16:3] battery_mv,
                                      // [18:17] port_state, [19] state_changed
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);
  import mpmac_pkg::*;

  logic [14:0] cal;
  logic [13:0] th_abs, th_full, th_float, th_fault;
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= 15'd16384; th_abs <= 14'd1500; th_full <= 14'd4180;
      th_float <= 14'd4230; th_fault <= 14'd4400;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAL:   if (cfg_wdata > 15'd8192) cal <= cfg_wdata;
        REG_ABS:   th_abs <= cfg_wdata[13:0];
        REG_FULL:  th_full <= cfg_wdata[13:0];
        REG_FLOAT: th_float <= cfg_wdata[13:0];
        REG_FAULT: th_fault <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  fsm_t st, st_next;
  logic [CW-1:0] count;
  cell_ctl_t ctl;
  logic [11:0] median;
  logic [PW-1:0] cur_port;

  logic [17:0] win [PORTS*WINDOW];
  logic [WIW-1:0] wptr [PORTS];
  logic [PORTS-1:0] filled, latch;
  logic [1:0] prev [PORTS];

  logic [WPW-1:0] n, si;
  logic [SUMW-1:0] sum;
  logic [17:0] rd;
  logic [SUMW+4:0] rem;
  logic [SUMW+4:0] dvs;
  logic [4:0] bitc;
  logic [SUMW:0] quo;
  logic [13:0] mv;
  logic        out_v;
  logic [23:0] out_d;
  logic        accept;
  logic [11:0] in_pin;
  logic [2:0]  in_port;

  assign in_port = s_axis_tdata[2:0];
  assign in_pin  = s_axis_tdata[14:3];
  assign s_axis_tready = (st == S_IDLE) && !out_v;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ctl.ins = accept && !s_axis_tuser;
  assign ctl.key = in_pin;

  mpmac_row u_row (.clk, .ctl, .count, .median);

  // scaled median, Q.4
  logic [27:0] prod;
  assign prod = 28'(median) * 28'(cal);
  logic [17:0] scaled;
  assign scaled = 18'((prod + 28'd256) >> 9);

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: if (ctl.ins) st_next = S_INS;
      S_INS:  if (count == CW'(SAMPLES)) begin
                st_next = (32'(cur_port) < PORTS) ? S_SUM : S_IDLE;
              end else st_next = S_IDLE;
      S_SUM:  if (si == n) st_next = S_DIV;
      // last quotient bit is resolved while bitc is 1
      S_DIV:  if (bitc == 5'd1) st_next = S_OUT;
      S_OUT:  st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE; else st <= st_next;
  end

  logic [WIW-1:0] p0, p1;
  always_comb begin
    p0 = wptr[cur_port[PW-1:0]];
    p1 = (32'(p0) + 1 >= WINDOW) ? '0 : WIW'(32'(p0) + 1);
  end

  // window store addresses: port base plus entry
  logic [WAW-1:0] raddr, waddr;
  assign raddr = WAW'(32'(cur_port) * WINDOW + 32'(si));
  assign waddr = WAW'(32'(cur_port) * WINDOW + 32'(p0));

  logic [13:0] mvs;
  logic [1:0] cls;
  logic nl;
  always_comb begin
    mvs = (quo > (SUMW+1)'(16383)) ? 14'd16383 : quo[13:0];
    nl = latch[cur_port];
    if (mvs >= th_fault) cls = ST_FAULT;
    else if (mvs >= th_float || mvs < th_abs) begin cls = ST_NONE; nl = 1'b0; end
    else begin
      if (mvs >= th_full) nl = 1'b1;
      cls = nl ? ST_FULL : ST_CHARGING;
    end
  end

  always_ff @(posedge clk) begin
    rd <= win[raddr];
    if (st == S_INS && count == CW'(SAMPLES) && 32'(cur_port) < PORTS)
      win[waddr] <= scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; filled <= '0; latch <= '0; out_v <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin wptr[i] <= '0; prev[i] <= ST_NONE; end
    end else begin
      if (out_v && m_axis_tready) out_v <= 1'b0;
      if (accept && s_axis_tuser) latch <= '0;
      if (ctl.ins) begin
        count <= (count == CW'(SAMPLES)) ? CW'(1) : count + CW'(1);
        cur_port <= in_port;
      end
      unique case (st)
        S_INS: if (count == CW'(SAMPLES) && 32'(cur_port) < PORTS) begin
          count <= '0;
          wptr[cur_port] <= p1;
          if (p1 == '0) filled[cur_port] <= 1'b1;
          n <= (filled[cur_port] || p1 == '0) ? WPW'(WINDOW) : WPW'(p1);
          si <= '0; sum <= '0;
        end else if (count == CW'(SAMPLES)) count <= '0;
        S_SUM: begin
          // rd is registered, so it holds the entry of the previous index
          if (si != '0) sum <= sum + SUMW'(rd);
          if (si == n) begin
            rem <= (SUMW+5)'(sum + SUMW'(rd)) + (SUMW+5)'({n, 3'b000});
            dvs <= (SUMW+5)'({n, 4'b0000});
            // the average never reaches 2^14, so 14 quotient bits suffice
            bitc <= 5'd14; quo <= '0;
          end else si <= si + WPW'(1);
        end
        S_DIV: begin
          bitc <= bitc - 5'd1;
          if (rem >= (dvs << (bitc - 5'd1))) begin
            rem <= rem - (dvs << (bitc - 5'd1));
            quo[bitc - 5'd1] <= 1'b1;
          end
        end
        S_OUT: begin
          latch[cur_port] <= nl;
          prev[cur_port] <= cls;
          out_v <= 1'b1;
          out_d <= {4'b0, cls != prev[cur_port], cls, mvs, cur_port};
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_d;
endmodule

// File: rtl/core/mpmac_checker.sv
// Port-level checker for the classifier, bound to the top level.
// Depends on multi_port_median_average_classifier ports only.
module mpmac_checker (
  input logic clk, input logic rst,
  input logic s_axis_tready, input logic m_axis_tvalid, input logic m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open with result pending");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0) else $error("pad bits set");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind multi_port_median_average_classifier mpmac_checker u_chk (.*);
